FILE: src/clkpr_pkg.sv
// ============================================================================
// Clock page replacement package
// Shared sizes, the sequencer state type and the shared step unit structs.
// ============================================================================
`default_nettype none

package clkpr_pkg;

    localparam int FRAMES    = 16;
    localparam int PAGE_BITS = 20;
    localparam int IDX_BITS  = $clog2(FRAMES);
    localparam int CNT_BITS  = $clog2(FRAMES + 1);
    localparam int CFG_BITS  = 5;
    localparam int FAULT_BITS = 32;

    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(16);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_EVICT,
        ST_FINISH
    } state_t;

    // Operands of the shared compare and index step unit.
    typedef struct packed {
        logic [CNT_BITS-1:0]  idx;
        logic [CNT_BITS-1:0]  scan_limit;
        logic [CNT_BITS-1:0]  wrap_limit;
        logic [PAGE_BITS-1:0] page;
        logic [PAGE_BITS-1:0] stored;
    } step_in_t;

    // Results of the shared compare and index step unit.
    typedef struct packed {
        logic                 match;
        logic                 in_range;
        logic [CNT_BITS-1:0]  idx_inc;
        logic [IDX_BITS-1:0]  idx_wrap;
    } step_out_t;

endpackage

`default_nettype wire

FILE: src/clkpr_if.sv
// ============================================================================
// Clock page replacement channels
// Valid/ready channels for page references, results and configuration.
// ============================================================================
`default_nettype none

interface clkpr_req_if import clkpr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

interface clkpr_rsp_if import clkpr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [IDX_BITS-1:0]   frame_index;
    logic                  evicted_valid;
    logic [PAGE_BITS-1:0]  evicted_page;
    logic [FAULT_BITS-1:0] fault_total;

    modport source (output valid, output hit, output frame_index, output evicted_valid,
                    output evicted_page, output fault_total, input ready);
    modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                    input evicted_page, input fault_total, output ready);
endinterface

interface clkpr_cfg_if import clkpr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] frames_in_use;

    modport source (output valid, output frames_in_use, input ready);
    modport sink   (input valid, input frames_in_use, output ready);
endinterface

`default_nettype wire

FILE: src/clock_page_replacement.sv
// ============================================================================
// Clock page replacement
// Second-chance frame table with a sequenced lookup and hand sweep.
// ============================================================================
// Steps: an accept step, a lookup over min(filled, active) frames, then on a
// full-table miss a hand sweep and one page read, then a commit step that
// waits for a free output slot; one item at a time. The lookup walks the frame
// RAM's single read port one frame per cycle; the sweep walks the use bits.
// Reset clears use bits, fill count, hand, fault count and frames_in_use = 16.
`default_nettype none

module clock_page_replacement import clkpr_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    clkpr_req_if.sink  req,
    clkpr_rsp_if.source rsp,
    clkpr_cfg_if.sink  cfg
);

    // Sequencer and table state.
    state_t                state_reg,    state_next;
    logic [CNT_BITS-1:0]   idx_reg,      idx_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [IDX_BITS-1:0]   cmp_idx_reg,  cmp_idx_next;
    logic [IDX_BITS-1:0]   frame_reg,    frame_next;
    logic                  hit_reg,      hit_next;
    logic                  evict_reg,    evict_next;
    logic [PAGE_BITS-1:0]  ev_page_reg,  ev_page_next;
    logic [PAGE_BITS-1:0]  page_reg,     page_next;
    logic [FRAMES-1:0]     use_reg,      use_next;
    logic [CNT_BITS-1:0]   filled_reg,   filled_next;
    logic [IDX_BITS-1:0]   hand_reg,     hand_next;
    logic [FAULT_BITS-1:0] fault_reg,    fault_next;
    logic [CFG_BITS-1:0]   cfg_reg;

    // Output register, which lets the next item in while a result waits.
    logic                  out_valid_reg, out_valid_next;
    logic                  out_hit_reg,   out_hit_next;
    logic [IDX_BITS-1:0]   out_frame_reg, out_frame_next;
    logic                  out_ev_reg,    out_ev_next;
    logic [PAGE_BITS-1:0]  out_evp_reg,   out_evp_next;
    logic [FAULT_BITS-1:0] out_fault_reg, out_fault_next;

    logic [CNT_BITS-1:0]   n_active;
    logic [CNT_BITS-1:0]   valid_cnt;
    logic                  ram_we;
    logic [PAGE_BITS-1:0]  ram_rdata;
    logic [FAULT_BITS-1:0] fault_inc;
    logic                  slot_free;
    step_in_t              step_op;
    step_out_t             step_res;

    // The register acts as 1 when zero and is clipped to the built frame count.
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            n_active = CNT_BITS'(1);
        end
        else if (cfg_reg > CFG_BITS'(FRAMES))
        begin
            n_active = CNT_BITS'(FRAMES);
        end
        else
        begin
            n_active = CNT_BITS'(cfg_reg);
        end
        valid_cnt = (filled_reg < n_active) ? filled_reg : n_active;
    end

    assign fault_inc = (fault_reg == '1) ? fault_reg : fault_reg + FAULT_BITS'(1);
    assign slot_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        step_op.idx        = idx_reg;
        step_op.scan_limit = valid_cnt;
        step_op.wrap_limit = n_active;
        step_op.page       = page_reg;
        step_op.stored     = ram_rdata;
    end

    clkpr_step_unit u_step (
        .op  (step_op),
        .res (step_res)
    );

    // Frame page store; its read data is only used at frames that have been filled.
    clkpr_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (FRAMES)
    ) u_frames (
        .clk   (clk),
        .we    (ram_we),
        .waddr (frame_reg),
        .wdata (page_reg),
        .raddr (idx_reg[IDX_BITS-1:0]),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.frame_index   = out_frame_reg;
    assign rsp.evicted_valid = out_ev_reg;
    assign rsp.evicted_page  = out_evp_reg;
    assign rsp.fault_total   = out_fault_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        frame_next     = frame_reg;
        hit_next       = hit_reg;
        evict_next     = evict_reg;
        ev_page_next   = ev_page_reg;
        page_next      = page_reg;
        use_next       = use_reg;
        filled_next    = filled_reg;
        hand_next      = hand_reg;
        fault_next     = fault_reg;
        ram_we         = 1'b0;

        out_valid_next = out_valid_reg && !rsp.ready;
        out_hit_next   = out_hit_reg;
        out_frame_next = out_frame_reg;
        out_ev_next    = out_ev_reg;
        out_evp_next   = out_evp_reg;
        out_fault_next = out_fault_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    page_next      = req.page_number;
                    idx_next       = '0;
                    cmp_valid_next = 1'b0;
                    state_next     = ST_SCAN;
                end
            end

            // One RAM read is issued per cycle and its data is compared in the next cycle.
            ST_SCAN:
            begin
                if (cmp_valid_reg && step_res.match)
                begin
                    hit_next     = 1'b1;
                    evict_next   = 1'b0;
                    ev_page_next = '0;
                    frame_next   = cmp_idx_reg;
                    state_next   = ST_FINISH;
                end
                else if (step_res.in_range)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = idx_reg[IDX_BITS-1:0];
                    idx_next       = step_res.idx_inc;
                end
                else
                begin
                    hit_next       = 1'b0;
                    cmp_valid_next = 1'b0;
                    if (filled_reg < n_active)
                    begin
                        evict_next   = 1'b0;
                        ev_page_next = '0;
                        frame_next   = filled_reg[IDX_BITS-1:0];
                        state_next   = ST_FINISH;
                    end
                    else
                    begin
                        // A hand left beyond the active count starts over at zero.
                        idx_next   = (CNT_BITS'(hand_reg) >= n_active) ? '0
                                                                       : CNT_BITS'(hand_reg);
                        state_next = ST_SWEEP;
                    end
                end
            end

            // Clear set use bits until a frame without one turns up.
            ST_SWEEP:
            begin
                if (!use_reg[idx_reg[IDX_BITS-1:0]])
                begin
                    evict_next = 1'b1;
                    frame_next = idx_reg[IDX_BITS-1:0];
                    state_next = ST_EVICT;
                end
                else
                begin
                    use_next[idx_reg[IDX_BITS-1:0]] = 1'b0;
                    idx_next = CNT_BITS'(step_res.idx_wrap);
                end
            end

            ST_EVICT:
            begin
                ev_page_next = ram_rdata;
                state_next   = ST_FINISH;
            end

            // All table updates bar sweep clears land together once a slot is free.
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    use_next[frame_reg] = 1'b1;
                    if (!hit_reg)
                    begin
                        ram_we     = 1'b1;
                        fault_next = fault_inc;
                        if (evict_reg)
                        begin
                            hand_next = step_res.idx_wrap;
                        end
                        else
                        begin
                            filled_next = filled_reg + CNT_BITS'(1);
                        end
                    end
                    out_valid_next = 1'b1;
                    out_hit_next   = hit_reg;
                    out_frame_next = frame_reg;
                    out_ev_next    = evict_reg;
                    out_evp_next   = ev_page_reg;
                    out_fault_next = hit_reg ? fault_reg : fault_inc;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmp_valid_reg <= 1'b0;
            use_reg       <= '0;
            filled_reg    <= '0;
            hand_reg      <= '0;
            fault_reg     <= '0;
            cfg_reg       <= CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            use_reg       <= use_next;
            filled_reg    <= filled_next;
            hand_reg      <= hand_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                cfg_reg <= cfg.frames_in_use;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        frame_reg     <= frame_next;
        hit_reg       <= hit_next;
        evict_reg     <= evict_next;
        ev_page_reg   <= ev_page_next;
        page_reg      <= page_next;
        out_hit_reg   <= out_hit_next;
        out_frame_reg <= out_frame_next;
        out_ev_reg    <= out_ev_next;
        out_evp_reg   <= out_evp_next;
        out_fault_reg <= out_fault_next;
    end

    // A new result only appears out of the commit step.
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result appeared outside the commit step");

    // A reference never both hits and evicts.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_hit_reg && out_ev_reg))
        else $error("hit reported together with an eviction");

    // The hand only sweeps over a full table.
    a_sweep_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP |-> filled_reg >= n_active)
        else $error("sweep started before the table was full");

    // The fill count stays within the built frames.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= CNT_BITS'(FRAMES))
        else $error("fill count beyond the frame table");

endmodule

`default_nettype wire

FILE: src/clkpr_ram.sv
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module clkpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/clkpr_step_unit.sv
// ============================================================================
// Clock page replacement step unit
// Shared page compare, range check and wrapping index increment.
// ============================================================================
`default_nettype none

module clkpr_step_unit import clkpr_pkg::*; (
    input  wire step_in_t  op,
    output step_out_t      res
);

    logic [CNT_BITS-1:0] inc;

    always_comb
    begin
        inc          = op.idx + CNT_BITS'(1);
        res.match    = (op.stored == op.page);
        res.in_range = (op.idx < op.scan_limit);
        res.idx_inc  = inc;
        res.idx_wrap = (inc == op.wrap_limit) ? '0 : inc[IDX_BITS-1:0];
    end

endmodule

`default_nettype wire

FILE: bench/tb_clock_page_replacement.sv
`timescale 1ns / 100ps
// ============================================================================
// Clock page replacement testbench
// Sends page references through the request channel and checks every result
// against a second-chance frame table predictor kept inside the bench. Phases
// use different frames_in_use settings and different idle patterns.
// ============================================================================

module tb_clock_page_replacement import clkpr_pkg::*; ();

    // Cycles without any handshake before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 11;
    localparam int PHASE_ITEMS    = 104;

    // Idle patterns, one per phase.
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic                  hit;
        logic [IDX_BITS-1:0]   frame_index;
        logic                  evicted_valid;
        logic [PAGE_BITS-1:0]  evicted_page;
        logic [FAULT_BITS-1:0] fault_total;
    } page_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    clkpr_req_if req_ch ();
    clkpr_rsp_if rsp_ch ();
    clkpr_cfg_if cfg_ch ();

    clock_page_replacement u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #2 clk = ~clk;

    // Page references waiting to be sent, and the results they must produce.
    logic [PAGE_BITS-1:0] pending_pages [$];
    page_result_t         expected_results [$];

    // The bench's own copy of the frame table and its register.
    logic [PAGE_BITS-1:0]  table_page [FRAMES];
    logic                  table_use [FRAMES];
    int unsigned           fill_count;
    int unsigned           hand_pos;
    logic [FAULT_BITS-1:0] fault_count;
    logic [CFG_BITS-1:0]   cfg_frames;

    int send_idle_pct;
    int recv_stall_pct;
    int error_count;
    int idle_cycles;

    // Number of frames that a register value actually manages: zero acts as
    // one and anything above the built size acts as the built size.
    function automatic int unsigned active_frames(input logic [CFG_BITS-1:0] value);
        if (value == 0)
            return 1;
        if (value > FRAMES)
            return FRAMES;
        return 32'(value);
    endfunction

    // Applies one accepted reference to the predicted table and queues the
    // result that the block has to return for it.
    function automatic void predict_reference(input logic [PAGE_BITS-1:0] page);
        int unsigned  n;
        int unsigned  searched;
        int unsigned  i;
        int unsigned  h;
        int unsigned  guard;
        int unsigned  frame;
        bit           found;
        page_result_t r;

        n = active_frames(cfg_frames);
        searched = (fill_count < n) ? fill_count : n;
        found = 1'b0;
        frame = 0;
        r = '0;

        // The lowest matching frame wins when a page is resident twice, which
        // can happen after the active count has shrunk and grown again.
        for (i = 0; i < searched; i++)
        begin
            if (!found && table_page[i] == page)
            begin
                found = 1'b1;
                frame = i;
            end
        end

        if (found)
        begin
            r.hit = 1'b1;
            table_use[frame] = 1'b1;
        end
        else
        begin
            if (fault_count != '1)
                fault_count++;
            if (fill_count < n)
            begin
                frame = fill_count;
                fill_count++;
            end
            else
            begin
                // A hand left beyond the active count restarts at frame 0.
                h = (hand_pos >= n) ? 0 : hand_pos;
                for (guard = 0; guard <= 2 * n; guard++)
                begin
                    if (!table_use[h])
                        break;
                    table_use[h] = 1'b0;
                    h = (h + 1 == n) ? 0 : h + 1;
                end
                frame = h;
                r.evicted_valid = 1'b1;
                r.evicted_page = table_page[frame];
                hand_pos = (h + 1 == n) ? 0 : h + 1;
            end
            table_page[frame] = page;
            table_use[frame] = 1'b1;
        end

        r.frame_index = IDX_BITS'(frame);
        r.fault_total = fault_count;
        expected_results = {expected_results, r};
    endfunction

    function automatic void compare_field(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
            error_count++;
        end
    endfunction

    // Request driver. A new item is offered only when the channel is free,
    // and the sender may hold back at random.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.page_number <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                predict_reference(req_ch.page_number);
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_pages.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.page_number <= pending_pages.pop_front();
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Every accepted result is matched against the oldest
    // expectation, and ready is dropped at random to stall the block.
    always @(posedge clk)
    begin
        page_result_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected, hit %0b frame %0d page 0x%0h",
                             $time, rsp_ch.hit, rsp_ch.frame_index, rsp_ch.evicted_page);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("hit", want.hit, rsp_ch.hit);
                    compare_field("frame_index", want.frame_index, rsp_ch.frame_index);
                    compare_field("evicted_valid", want.evicted_valid, rsp_ch.evicted_valid);
                    compare_field("evicted_page", want.evicted_page, rsp_ch.evicted_page);
                    compare_field("fault_total", want.fault_total, rsp_ch.fault_total);
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:
            begin
                send_idle_pct = 58;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 58;
            end
            IDLE_BOTH:
            begin
                send_idle_pct = 11;
                recv_stall_pct = 11;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // Waits until every queued item has been sent and answered. The check is
    // made at the falling edge so it never races the clocked blocks.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_pages.size() != 0 || req_ch.valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Register write, issued only while the block is idle. The predictor takes
    // the new value at the same edge as the block.
    task automatic write_frames_in_use(input logic [CFG_BITS-1:0] value);
        wait_drained();
        repeat (4) @(negedge clk);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.frames_in_use <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_frames = value;
        cfg_ch.valid <= 1'b0;
    endtask

    // Queues one phase of random references. Most come from a working set
    // one to n + 3 pages larger than the active frame count, so hits, second
    // chances and evictions all occur; the rest are arbitrary pages.
    task automatic queue_random_phase(input int count, input int unsigned n);
        logic [PAGE_BITS-1:0] working_set [$];
        int                   set_size;
        int                   k;
        int                   pick;
        logic [PAGE_BITS-1:0] page;

        set_size = n + $urandom_range(1, n + 3);
        for (k = 0; k < set_size; k++)
            working_set = {working_set, PAGE_BITS'($urandom)};
        @(negedge clk);
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 82)
                page = working_set[$urandom_range(0, set_size - 1)];
            else if (pick < 96)
                page = PAGE_BITS'($urandom);
            else if (pick < 98)
                page = '0;
            else
                page = '1;
            pending_pages = {pending_pages, page};
        end
    endtask

    initial
    begin
        idle_mode_t modes [4];
        int         phase_cfg [RANDOM_PHASES];
        int         p;

        modes = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
        phase_cfg = '{16, 1, 7, 0, 31, 4, 16, 12, 2, 20, 16};

        // Every block input holds a known value from time zero.
        req_ch.valid = 1'b0;
        req_ch.page_number = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.frames_in_use = '0;

        // Predictor state after reset.
        for (p = 0; p < FRAMES; p++)
        begin
            table_page[p] = '0;
            table_use[p] = 1'b0;
        end
        fill_count = 0;
        hand_pos = 0;
        fault_count = '0;
        cfg_frames = CFG_RESET;
        error_count = 0;
        idle_cycles = 0;
        set_idling(IDLE_NONE);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset setting of sixteen frames: the page
        // extremes, hits on them, then two more pages.
        pending_pages = '{20'h00000, 20'hFFFFF, 20'h00000, 20'hFFFFF, 20'h55555, 20'hAAAAA};

        // Shrink below the fill: only the first three frames are searched, and
        // misses make the hand sweep and evict.
        write_frames_in_use(5'd3);
        pending_pages = '{20'h55555, 20'h12345, 20'h00000, 20'h55555, 20'hFFFFF, 20'h00001};

        // An out-of-range value acts as sixteen. The fill resumes above the
        // old pages, and the page left in frame 3 is searched and hits again.
        write_frames_in_use(5'd31);
        pending_pages = '{20'h55555, 20'hAAAAA, 20'h00002};

        // Zero acts as one frame: every miss evicts frame 0.
        write_frames_in_use(5'd0);
        pending_pages = '{20'h00003, 20'h00003, 20'h00004};

        write_frames_in_use(5'd1);
        pending_pages = '{20'h00004, 20'h00005};

        // Random phases, each with its own setting and idle pattern.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            write_frames_in_use(CFG_BITS'(phase_cfg[p]));
            set_idling(modes[p % 4]);
            queue_random_phase(PHASE_ITEMS, active_frames(CFG_BITS'(phase_cfg[p])));
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
